>>> hw/rtl/mt_gen_pkg.sv
// Package for the MT19937 word generator: constants, types and the tempering function.
package mt_gen_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;

    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_RD_I,
        ST_RD_N,
        ST_RD_F,
        ST_TWIST,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_SEL_I,
        RD_SEL_N,
        RD_SEL_F
    } t_rd_sel;

    typedef struct packed {
        logic    seed_start;
        logic    seed_mul;
        logic    seed_wr;
        t_rd_sel rd_sel;
        logic    cap_i;
        logic    cap_n;
        logic    twist;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic need_seed;
        logic seed_last;
        logic out_free;
    } t_stat;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] t;
        begin
            t = x ^ (x >> 11);
            t = t ^ ((t << 7) & TEMPER_B);
            t = t ^ ((t << 15) & TEMPER_C);
            t = t ^ (t >> 18);
            return t;
        end
    endfunction

endpackage

>>> hw/rtl/mt_gen_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mt_gen_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mt_gen_ctrl.sv
// Controller state machine for the MT19937 word generator.
module mt_gen_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mt_gen_pkg::t_stat i_stat,
    output logic              o_in_ready,
    output mt_gen_pkg::t_cmd  o_cmd
);

    mt_gen_pkg::t_state r_state;
    mt_gen_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mt_gen_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mt_gen_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.need_seed ? mt_gen_pkg::ST_SEED_MUL : mt_gen_pkg::ST_RD_I;
                end
            end
            mt_gen_pkg::ST_SEED_MUL: n_state = mt_gen_pkg::ST_SEED_WR;
            mt_gen_pkg::ST_SEED_WR: begin
                n_state = i_stat.seed_last ? mt_gen_pkg::ST_RD_I : mt_gen_pkg::ST_SEED_MUL;
            end
            mt_gen_pkg::ST_RD_I:  n_state = mt_gen_pkg::ST_RD_N;
            mt_gen_pkg::ST_RD_N:  n_state = mt_gen_pkg::ST_RD_F;
            mt_gen_pkg::ST_RD_F:  n_state = mt_gen_pkg::ST_TWIST;
            mt_gen_pkg::ST_TWIST: n_state = mt_gen_pkg::ST_EMIT;
            mt_gen_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = mt_gen_pkg::ST_IDLE;
                end
            end
            default: n_state = mt_gen_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel = mt_gen_pkg::RD_SEL_I;
        case (r_state)
            mt_gen_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.seed_start = i_in_valid & i_stat.need_seed;
            end
            mt_gen_pkg::ST_SEED_MUL: o_cmd.seed_mul = 1'b1;
            mt_gen_pkg::ST_SEED_WR:  o_cmd.seed_wr  = 1'b1;
            mt_gen_pkg::ST_RD_I:     o_cmd.rd_sel   = mt_gen_pkg::RD_SEL_I;
            mt_gen_pkg::ST_RD_N: begin
                o_cmd.rd_sel = mt_gen_pkg::RD_SEL_N;
                o_cmd.cap_i  = 1'b1;
            end
            mt_gen_pkg::ST_RD_F: begin
                o_cmd.rd_sel = mt_gen_pkg::RD_SEL_F;
                o_cmd.cap_n  = 1'b1;
            end
            mt_gen_pkg::ST_TWIST:    o_cmd.twist = 1'b1;
            mt_gen_pkg::ST_EMIT:     o_cmd.emit  = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mt_gen_dp.sv
// Datapath for the MT19937 word generator: seed recurrence, twist, tempering, output register.
module mt_gen_dp #(
    parameter int STATE_WORDS  = mt_gen_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mt_gen_pkg::TWIST_OFFSET
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_reseed,
    input  mt_gen_pkg::t_cmd i_cmd,
    output mt_gen_pkg::t_stat o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [31:0]      o_out_data
);

    localparam int IDX_W = $clog2(STATE_WORDS);

    logic [31:0]      r_seed;
    logic [IDX_W-1:0] r_idx;
    logic             r_seeded;
    logic [IDX_W-1:0] r_k;
    logic [31:0]      r_prev;
    logic [31:0]      r_prod;
    logic [31:0]      r_wi;
    logic [31:0]      r_wn;
    logic [31:0]      r_x;
    logic [31:0]      r_out;
    logic             r_out_valid;

    logic [IDX_W-1:0] w_nxt;
    logic [IDX_W:0]   w_far_sum;
    logic [IDX_W-1:0] w_far;
    logic [31:0]      w_seed_eff;
    logic [31:0]      w_seed_word;
    logic [31:0]      w_y;
    logic [31:0]      w_twist;
    logic [31:0]      w_rdata;
    logic [IDX_W-1:0] w_raddr;
    logic [IDX_W-1:0] w_waddr;
    logic [31:0]      w_wdata;
    logic             w_we;

    assign w_nxt      = (r_idx == IDX_W'(STATE_WORDS - 1)) ? '0 : r_idx + 1'b1;
    assign w_far_sum  = {1'b0, r_idx} + (IDX_W + 1)'(TWIST_OFFSET);
    assign w_far      = (w_far_sum >= (IDX_W + 1)'(STATE_WORDS))
                      ? IDX_W'(w_far_sum - (IDX_W + 1)'(STATE_WORDS))
                      : w_far_sum[IDX_W-1:0];
    assign w_seed_eff  = (r_seed == '0) ? mt_gen_pkg::DEFAULT_SEED : r_seed;
    assign w_seed_word = r_prod + {{(32 - IDX_W){1'b0}}, r_k};
    assign w_y         = {r_wi[31], r_wn[30:0]};
    assign w_twist     = w_rdata ^ (w_y >> 1) ^ (w_y[0] ? mt_gen_pkg::TWIST_MATRIX : '0);

    always_comb begin
        case (i_cmd.rd_sel)
            mt_gen_pkg::RD_SEL_I: w_raddr = r_idx;
            mt_gen_pkg::RD_SEL_N: w_raddr = w_nxt;
            mt_gen_pkg::RD_SEL_F: w_raddr = w_far;
            default:              w_raddr = r_idx;
        endcase
    end

    always_comb begin
        w_we    = i_cmd.seed_start | i_cmd.seed_wr | i_cmd.twist;
        w_waddr = r_idx;
        w_wdata = w_twist;
        if (i_cmd.seed_start) begin
            w_waddr = '0;
            w_wdata = w_seed_eff;
        end else if (i_cmd.seed_wr) begin
            w_waddr = r_k;
            w_wdata = w_seed_word;
        end
    end

    mt_gen_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= mt_gen_pkg::DEFAULT_SEED;
            r_idx       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.seed_start) begin
                r_idx    <= '0;
                r_seeded <= 1'b1;
            end else if (i_cmd.twist) begin
                r_idx <= w_nxt;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_prev <= w_seed_eff;
            r_k    <= IDX_W'(1);
        end
        if (i_cmd.seed_mul) begin
            r_prod <= mt_gen_pkg::INIT_MULT * (r_prev ^ (r_prev >> 30));
        end
        if (i_cmd.seed_wr) begin
            r_prev <= w_seed_word;
            r_k    <= r_k + 1'b1;
        end
        if (i_cmd.cap_i) begin
            r_wi <= w_rdata;
        end
        if (i_cmd.cap_n) begin
            r_wn <= w_rdata;
        end
        if (i_cmd.twist) begin
            r_x <= w_twist;
        end
        if (i_cmd.emit) begin
            r_out <= mt_gen_pkg::temper(r_x);
        end
    end

    assign o_stat.need_seed = i_reseed | ~r_seeded;
    assign o_stat.seed_last = (r_k == IDX_W'(STATE_WORDS - 1));
    assign o_stat.out_free  = ~r_out_valid | i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

>>> hw/rtl/mt19937_word_generator_unit.sv
// MT19937 word generator: one tempered 32-bit word per input item. A draw does three reads
// of the 624-word state RAM through its single read port, one twist with write-back and
// one tempering stage into the output register, which waits while an untaken result is
// still held there; the next item is accepted in the cycle after that tempering stage. Seeding,
// done on the first item after reset or when bit 0 of the input item is set, writes word 0
// on acceptance and then runs each seed recurrence step through the registered multiplier.
// A result left waiting in the output register does not block acceptance of the next item.
module mt19937_word_generator_unit #(
    parameter int STATE_WORDS  = mt_gen_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mt_gen_pkg::TWIST_OFFSET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,         // seed_value
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,      // [0] reseed_first, [7:1] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata       // [31:0] random_word
);

    mt_gen_pkg::t_cmd  w_cmd;
    mt_gen_pkg::t_stat w_stat;

    mt_gen_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    mt_gen_dp #(
        .STATE_WORDS  (STATE_WORDS),
        .TWIST_OFFSET (TWIST_OFFSET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_reseed    (i_s_axis_tdata[0]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

>>> hw/rtl/mt_gen_chk.sv
// Port-level checker for the MT19937 word generator, bound to the top level.
module mt_gen_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output item changed");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared one cycle after acceptance");

    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result loaded while input side was ready");

endmodule

bind mt19937_word_generator_unit mt_gen_chk u_mt_gen_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> dv/tb_mt19937_word_generator_unit.sv
`timescale 1ns / 100ps
// Testbench for the MT19937 word generator: stream driver, word predictor and checker.
module tb_mt19937_word_generator_unit;

    localparam int          WDOG_LIMIT   = 20000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_SHOWN    = 10;
    localparam logic [31:0] UPPER_MASK   = 32'h80000000;
    localparam logic [31:0] LOWER_MASK   = 32'h7fffffff;
    localparam logic [7:0]  REQ_DRAW     = 8'h00;
    localparam logic [7:0]  REQ_RESEED   = 8'h01;
    localparam logic [7:0]  PAD_NOISE    = 8'hfe;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [31:0] i_cfg_wdata     = 32'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;    // [0] reseed_first, [7:1] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;            // [31:0] random_word

    // predictor state
    logic [31:0] mt_vec [mt_gen_pkg::STATE_WORDS];
    int unsigned mt_idx    = 0;
    bit          mt_seeded = 1'b0;
    logic [31:0] seed_reg  = mt_gen_pkg::DEFAULT_SEED;

    logic [7:0]  request_q[$];
    logic [31:0] pending_words[$];
    logic [31:0] want_word;
    int          idle_pct     = 33;
    int          stall_pct    = 33;
    int          mism_cnt     = 0;
    int          quiet_cycles = 0;

    mt19937_word_generator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void seed_vec();
        logic [31:0] p;
        mt_vec[0] = (seed_reg == 32'd0) ? mt_gen_pkg::DEFAULT_SEED : seed_reg;
        for (int k = 1; k < mt_gen_pkg::STATE_WORDS; k++) begin
            p         = mt_vec[k-1];
            mt_vec[k] = mt_gen_pkg::INIT_MULT * (p ^ (p >> 30)) + 32'(k);
        end
        mt_idx    = 0;
        mt_seeded = 1'b1;
    endfunction

    function automatic logic [31:0] next_word(logic reseed);
        int unsigned nxt;
        int unsigned far;
        logic [31:0] y;
        logic [31:0] x;
        if (reseed || !mt_seeded)
            seed_vec();
        nxt = (mt_idx + 1) % mt_gen_pkg::STATE_WORDS;
        far = (mt_idx + mt_gen_pkg::TWIST_OFFSET) % mt_gen_pkg::STATE_WORDS;
        y = (mt_vec[mt_idx] & UPPER_MASK) | (mt_vec[nxt] & LOWER_MASK);
        x = mt_vec[far] ^ (y >> 1) ^ (y[0] ? mt_gen_pkg::TWIST_MATRIX : 32'd0);
        mt_vec[mt_idx] = x;
        mt_idx = nxt;
        x = x ^ (x >> 11);
        x = x ^ ((x << 7) & mt_gen_pkg::TEMPER_B);
        x = x ^ ((x << 15) & mt_gen_pkg::TEMPER_C);
        x = x ^ (x >> 18);
        return x;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= REQ_DRAW;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= request_q.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            pending_words.push_back(next_word(i_s_axis_tdata[0]));
    end

    // word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_words.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= MAX_SHOWN)
                    $display("unexpected word %h", o_m_axis_tdata);
            end else begin
                want_word = pending_words.pop_front();
                if (o_m_axis_tdata !== want_word) begin
                    mism_cnt++;
                    if (mism_cnt <= MAX_SHOWN)
                        $display("word mismatch: exp %h got %h", want_word, o_m_axis_tdata);
                end
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (request_q.size() != 0 || i_s_axis_tvalid || pending_words.size() != 0);
    endtask

    task automatic write_seed(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        seed_reg     = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_draws(int count, int reseed_odds);
        for (int n = 0; n < count; n++) begin
            if (reseed_odds > 0 && $urandom_range(reseed_odds - 1) == 0)
                request_q.push_back(REQ_RESEED);
            else
                request_q.push_back(REQ_DRAW);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset seed, first item asks no reseed; pad bits set on the two items before the last
        request_q = '{REQ_DRAW, REQ_DRAW, REQ_DRAW, REQ_RESEED, REQ_DRAW,
                      REQ_DRAW | PAD_NOISE, REQ_RESEED | PAD_NOISE, REQ_DRAW};
        wait_idle();

        // zero seed; new seed only used after the reseed item
        write_seed(32'd0);
        request_q = '{REQ_DRAW, REQ_RESEED, REQ_DRAW, REQ_DRAW};
        wait_idle();

        write_seed(32'hffffffff);
        request_q = '{REQ_RESEED, REQ_DRAW, REQ_DRAW};
        wait_idle();

        write_seed(32'd1);
        request_q = '{REQ_RESEED, REQ_DRAW};
        wait_idle();

        // long run without idling, past the state wrap
        idle_pct  = 0;
        stall_pct = 0;
        write_seed($urandom);
        request_q.push_back(REQ_RESEED);
        queue_draws(699, 0);
        wait_idle();

        idle_pct  = 33;
        stall_pct = 33;
        write_seed(mt_gen_pkg::DEFAULT_SEED);
        queue_draws(200, 25);
        wait_idle();

        write_seed($urandom);
        queue_draws(230, 40);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mism_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
